/* hdl/lccf_pkg.sv */
// Package for the loop closure candidate finder: payload structs, register
// indexes, the pose unit micro-op table and small helper functions.
// No dependencies.
`timescale 1ns / 1ps
package lccf_pkg;

  localparam int KF_DEPTH    = 1024;
  localparam int ADDR_W      = $clog2(KF_DEPTH);
  localparam int CNT_W       = $clog2(KF_DEPTH + 1);
  localparam int MAX_MATCHES = 64;
  localparam int MATCH_W     = $clog2(MAX_MATCHES + 1);
  localparam int LAST_STEP   = 49;
  localparam int STEP_W      = 6;

  localparam logic [31:0] RST_TIME_GAP = 32'd30000;
  localparam logic [30:0] RST_DIST_LIM = 31'd1638400;
  localparam logic [15:0] RST_MIN_GAP  = 16'd50;
  localparam logic [15:0] RST_ID_SKIP  = 16'd0;

  typedef enum logic [1:0] {
    CFG_TIME_GAP = 2'd0,
    CFG_DIST_LIM = 2'd1,
    CFG_MIN_GAP  = 2'd2,
    CFG_ID_SKIP  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        kf_id;
    logic [31:0]        time_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } kf_in_t;

  typedef struct packed {
    logic               found;
    logic [15:0]        id_new;
    logic [15:0]        id_old;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic signed [15:0] rel_qw;
    logic signed [15:0] rel_qx;
    logic signed [15:0] rel_qy;
    logic signed [15:0] rel_qz;
    logic               last;
    logic               overflow;
  } cand_out_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] time_ms;
    vec_t        pos;
    quat_t       quat;
  } store_entry_t;

  typedef struct packed {
    logic start;
    logic rel_en;
  } pose_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } pose_stat_t;

  typedef enum logic [4:0] {
    SRC_QNW, SRC_QNX, SRC_QNY, SRC_QNZ,
    SRC_QOW, SRC_QOX, SRC_QOY, SRC_QOZ,
    SRC_D0, SRC_D1, SRC_D2,
    SRC_R00, SRC_R01, SRC_R02,
    SRC_R10, SRC_R11, SRC_R12,
    SRC_R20, SRC_R21, SRC_R22,
    SRC_LIM, SRC_ONE
  } src_e;

  typedef enum logic [4:0] {
    DST_NONE, DST_DIST,
    DST_Q0, DST_Q1, DST_Q2, DST_Q3,
    DST_R00, DST_R01, DST_R02,
    DST_R10, DST_R11, DST_R12,
    DST_R20, DST_R21, DST_R22,
    DST_T0, DST_T1, DST_T2
  } dst_e;

  typedef struct packed {
    src_e a;
    src_e b;
    logic neg;
    logic dbl;
    logic first;
    dst_e dst;
  } uop_t;

  function automatic uop_t mk(src_e a, src_e b, logic neg, logic dbl, logic first,
                              dst_e dst);
    uop_t u;
    u.a = a;
    u.b = b;
    u.neg = neg;
    u.dbl = dbl;
    u.first = first;
    u.dst = dst;
    return u;
  endfunction

  // Squared distance test, then conj(q_new) * q_old, the rotation matrix of
  // q_new and finally the rotated translation.
  function automatic uop_t uop(logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      6'd0:  u = mk(SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd1:  u = mk(SRC_D1, SRC_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd2:  u = mk(SRC_D2, SRC_D2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd3:  u = mk(SRC_LIM, SRC_LIM, 1'b1, 1'b0, 1'b0, DST_DIST);
      6'd4:  u = mk(SRC_QNW, SRC_QOW, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd5:  u = mk(SRC_QNX, SRC_QOX, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd6:  u = mk(SRC_QNY, SRC_QOY, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd7:  u = mk(SRC_QNZ, SRC_QOZ, 1'b0, 1'b0, 1'b0, DST_Q0);
      6'd8:  u = mk(SRC_QNW, SRC_QOX, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd9:  u = mk(SRC_QNX, SRC_QOW, 1'b1, 1'b0, 1'b0, DST_NONE);
      6'd10: u = mk(SRC_QNY, SRC_QOZ, 1'b1, 1'b0, 1'b0, DST_NONE);
      6'd11: u = mk(SRC_QNZ, SRC_QOY, 1'b0, 1'b0, 1'b0, DST_Q1);
      6'd12: u = mk(SRC_QNW, SRC_QOY, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd13: u = mk(SRC_QNX, SRC_QOZ, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd14: u = mk(SRC_QNY, SRC_QOW, 1'b1, 1'b0, 1'b0, DST_NONE);
      6'd15: u = mk(SRC_QNZ, SRC_QOX, 1'b1, 1'b0, 1'b0, DST_Q2);
      6'd16: u = mk(SRC_QNW, SRC_QOZ, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd17: u = mk(SRC_QNX, SRC_QOY, 1'b1, 1'b0, 1'b0, DST_NONE);
      6'd18: u = mk(SRC_QNY, SRC_QOX, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd19: u = mk(SRC_QNZ, SRC_QOW, 1'b1, 1'b0, 1'b0, DST_Q3);
      6'd20: u = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd21: u = mk(SRC_QNY, SRC_QNY, 1'b1, 1'b1, 1'b0, DST_NONE);
      6'd22: u = mk(SRC_QNZ, SRC_QNZ, 1'b1, 1'b1, 1'b0, DST_R00);
      6'd23: u = mk(SRC_QNX, SRC_QNY, 1'b0, 1'b1, 1'b1, DST_NONE);
      6'd24: u = mk(SRC_QNW, SRC_QNZ, 1'b1, 1'b1, 1'b0, DST_R01);
      6'd25: u = mk(SRC_QNX, SRC_QNZ, 1'b0, 1'b1, 1'b1, DST_NONE);
      6'd26: u = mk(SRC_QNW, SRC_QNY, 1'b0, 1'b1, 1'b0, DST_R02);
      6'd27: u = mk(SRC_QNX, SRC_QNY, 1'b0, 1'b1, 1'b1, DST_NONE);
      6'd28: u = mk(SRC_QNW, SRC_QNZ, 1'b0, 1'b1, 1'b0, DST_R10);
      6'd29: u = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd30: u = mk(SRC_QNX, SRC_QNX, 1'b1, 1'b1, 1'b0, DST_NONE);
      6'd31: u = mk(SRC_QNZ, SRC_QNZ, 1'b1, 1'b1, 1'b0, DST_R11);
      6'd32: u = mk(SRC_QNY, SRC_QNZ, 1'b0, 1'b1, 1'b1, DST_NONE);
      6'd33: u = mk(SRC_QNW, SRC_QNX, 1'b1, 1'b1, 1'b0, DST_R12);
      6'd34: u = mk(SRC_QNX, SRC_QNZ, 1'b0, 1'b1, 1'b1, DST_NONE);
      6'd35: u = mk(SRC_QNW, SRC_QNY, 1'b1, 1'b1, 1'b0, DST_R20);
      6'd36: u = mk(SRC_QNY, SRC_QNZ, 1'b0, 1'b1, 1'b1, DST_NONE);
      6'd37: u = mk(SRC_QNW, SRC_QNX, 1'b0, 1'b1, 1'b0, DST_R21);
      6'd38: u = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd39: u = mk(SRC_QNX, SRC_QNX, 1'b1, 1'b1, 1'b0, DST_NONE);
      6'd40: u = mk(SRC_QNY, SRC_QNY, 1'b1, 1'b1, 1'b0, DST_R22);
      6'd41: u = mk(SRC_R00, SRC_D0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd42: u = mk(SRC_R10, SRC_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd43: u = mk(SRC_R20, SRC_D2, 1'b0, 1'b0, 1'b0, DST_T0);
      6'd44: u = mk(SRC_R01, SRC_D0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd45: u = mk(SRC_R11, SRC_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd46: u = mk(SRC_R21, SRC_D2, 1'b0, 1'b0, 1'b0, DST_T1);
      6'd47: u = mk(SRC_R02, SRC_D0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd48: u = mk(SRC_R12, SRC_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd49: u = mk(SRC_R22, SRC_D2, 1'b0, 1'b0, 1'b0, DST_T2);
      default: u = mk(SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b1, DST_NONE);
    endcase
    return u;
  endfunction

  function automatic logic signed [15:0] clamp_q(logic signed [15:0] v);
    if (v > 16'sd16384) begin
      return 16'sd16384;
    end else if (v < -16'sd16384) begin
      return -16'sd16384;
    end
    return v;
  endfunction

  function automatic logic [15:0] absdiff16(logic [15:0] a, logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [31:0] absdiff32(logic [31:0] a, logic [31:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

/* hdl/lccf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hdl/lccf_pose_unit.sv */
// Sequenced multiply-accumulate unit: squared distance test and relative pose.
// Depends on lccf_pkg.
`timescale 1ns / 1ps
module lccf_pose_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lccf_pkg::pose_cmd_t  cmd_i,
  input  lccf_pkg::quat_t      qn_i,
  input  lccf_pkg::quat_t      qo_i,
  input  lccf_pkg::vec_t       d_i,
  input  logic [30:0]          lim_i,
  output lccf_pkg::pose_stat_t stat_o,
  output lccf_pkg::quat_t      rq_o,
  output lccf_pkg::vec_t       rt_o
);
  import lccf_pkg::*;

  logic                     run_q;
  logic                     done_q;
  logic                     hit_q;
  logic                     rel_en_q;
  logic [STEP_W-1:0]        step_q;
  logic signed [65:0]       acc_q;
  logic signed [31:0]       r_q [9];
  quat_t                    rq_q;
  vec_t                     rt_q;

  uop_t                     op;
  logic signed [31:0]       src_a;
  logic signed [31:0]       opa;
  logic signed [31:0]       opb;
  logic signed [63:0]       prod;
  logic signed [65:0]       term;
  logic signed [65:0]       acc_sum;
  logic signed [65:0]       q_rnd;
  logic signed [65:0]       t_rnd;
  logic signed [15:0]       q_val;
  logic signed [31:0]       t_val;
  logic                     neg_sum;

  function automatic logic signed [31:0] sel(src_e s, quat_t qn, quat_t qo, vec_t d,
                                             logic [30:0] lim,
                                             logic signed [31:0] r0, logic signed [31:0] r1,
                                             logic signed [31:0] r2, logic signed [31:0] r3,
                                             logic signed [31:0] r4, logic signed [31:0] r5,
                                             logic signed [31:0] r6, logic signed [31:0] r7,
                                             logic signed [31:0] r8);
    logic signed [31:0] v;
    case (s)
      SRC_QNW: v = 32'(qn.w);
      SRC_QNX: v = 32'(qn.x);
      SRC_QNY: v = 32'(qn.y);
      SRC_QNZ: v = 32'(qn.z);
      SRC_QOW: v = 32'(qo.w);
      SRC_QOX: v = 32'(qo.x);
      SRC_QOY: v = 32'(qo.y);
      SRC_QOZ: v = 32'(qo.z);
      SRC_D0:  v = d.x;
      SRC_D1:  v = d.y;
      SRC_D2:  v = d.z;
      SRC_R00: v = r0;
      SRC_R01: v = r1;
      SRC_R02: v = r2;
      SRC_R10: v = r3;
      SRC_R11: v = r4;
      SRC_R12: v = r5;
      SRC_R20: v = r6;
      SRC_R21: v = r7;
      SRC_R22: v = r8;
      SRC_LIM: v = $signed({1'b0, lim});
      SRC_ONE: v = 32'sd16384;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op      = uop(step_q);
    src_a   = sel(op.a, qn_i, qo_i, d_i, lim_i, r_q[0], r_q[1], r_q[2], r_q[3], r_q[4],
                  r_q[5], r_q[6], r_q[7], r_q[8]);
    opa     = op.dbl ? (src_a <<< 1) : src_a;
    opb     = sel(op.b, qn_i, qo_i, d_i, lim_i, r_q[0], r_q[1], r_q[2], r_q[3], r_q[4],
                  r_q[5], r_q[6], r_q[7], r_q[8]);
    prod    = opa * opb;
    term    = op.neg ? -66'(prod) : 66'(prod);
    acc_sum = (op.first ? 66'sd0 : acc_q) + term;
    neg_sum = acc_sum[65];
    q_rnd   = (acc_sum + 66'sd8192) >>> 14;
    t_rnd   = (acc_sum + 66'sd134217728) >>> 28;
    if (q_rnd > 66'sd16384) begin
      q_val = 16'sd16384;
    end else if (q_rnd < -66'sd16384) begin
      q_val = -16'sd16384;
    end else begin
      q_val = q_rnd[15:0];
    end
    if (t_rnd > 66'sd2147483647) begin
      t_val = 32'sh7fffffff;
    end else if (t_rnd < -66'sd2147483648) begin
      t_val = 32'sh80000000;
    end else begin
      t_val = t_rnd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      rel_en_q <= 1'b0;
      step_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        run_q    <= 1'b1;
        rel_en_q <= cmd_i.rel_en;
        step_q   <= '0;
      end else if (run_q) begin
        if (op.dst == DST_DIST) begin
          hit_q <= neg_sum;
          if (!neg_sum || !rel_en_q) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end else if (step_q == STEP_W'(LAST_STEP)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      acc_q <= acc_sum;
      case (op.dst)
        DST_Q0:  rq_q.w <= q_val;
        DST_Q1:  rq_q.x <= q_val;
        DST_Q2:  rq_q.y <= q_val;
        DST_Q3:  rq_q.z <= q_val;
        DST_R00: r_q[0] <= acc_sum[31:0];
        DST_R01: r_q[1] <= acc_sum[31:0];
        DST_R02: r_q[2] <= acc_sum[31:0];
        DST_R10: r_q[3] <= acc_sum[31:0];
        DST_R11: r_q[4] <= acc_sum[31:0];
        DST_R12: r_q[5] <= acc_sum[31:0];
        DST_R20: r_q[6] <= acc_sum[31:0];
        DST_R21: r_q[7] <= acc_sum[31:0];
        DST_R22: r_q[8] <= acc_sum[31:0];
        DST_T0:  rt_q.x <= t_val;
        DST_T1:  rt_q.y <= t_val;
        DST_T2:  rt_q.z <= t_val;
        default: ;
      endcase
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.hit  = hit_q;
  assign rq_o        = rq_q;
  assign rt_o        = rt_q;

endmodule

/* hdl/loop_closure_candidate_finder_top.sv */
// Top level of the loop closure candidate finder: keyframe ring store, scan
// control, candidate holding stage and output register.
// Depends on lccf_pkg, lccf_ram and lccf_pose_unit.
//
//   Channel   Signals                          Direction
//   input     in_valid_i/in_ready_o/in_data_i  keyframe in
//   output    out_valid_o/out_ready_i/out_data_o  result out
//   config    cfg_we_i/cfg_index_i/cfg_wdata_i write only
//
// A keyframe scans the stored entries one at a time through the store's read
// port: a rejected entry is only read and checked, one that passes the checks
// runs the distance test in the pose unit, and a candidate also gets its
// relative pose computed and handed to the output stage.
// Reset empties the store at once by clearing the fill count; no sweep runs.
// A stalled output holds the scan at the next candidate or at the end.
`timescale 1ns / 1ps
module loop_closure_candidate_finder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lccf_pkg::kf_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lccf_pkg::cand_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i
);
  import lccf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_POSE, ST_HAND, ST_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [31:0]         time_gap_q;
  logic [30:0]         dist_lim_q;
  logic [15:0]         min_gap_q;
  logic [15:0]         id_skip_q;

  logic [CNT_W-1:0]    fill_q;
  logic [ADDR_W-1:0]   wslot_q;
  logic [CNT_W-1:0]    k_q;
  logic                have_q;
  logic [15:0]         mnew_q;
  logic [15:0]         mold_q;
  logic [MATCH_W-1:0]  n_q;
  logic                ovf_q;

  store_entry_t        kf_q;
  store_entry_t        rd_entry;
  logic [$bits(store_entry_t)-1:0] rdata;
  logic [15:0]         oid_q;
  quat_t               qo_q;
  vec_t                d_q;

  cand_out_t           pend_q;
  logic                pend_v_q;
  cand_out_t           out_q;
  logic                out_valid_q;

  pose_cmd_t           pose_cmd;
  pose_stat_t          pose_stat;
  quat_t               rq;
  vec_t                rt;

  logic                in_xfer;
  logic                out_free;
  logic                ram_re;
  logic                ram_we;
  logic [ADDR_W-1:0]   raddr;
  logic                advance;
  logic                last_k;
  logic                skip_new;
  logic                pass;
  logic                rel_en;
  logic signed [32:0]  dx, dy, dz;
  logic [32:0]         ax, ay, az;
  logic [32:0]         lim_ext;
  store_entry_t        new_entry;
  cand_out_t           cur_cand;
  cand_out_t           fin_cand;

  assign rd_entry = store_entry_t'(rdata);
  assign out_free = !out_valid_q || out_ready_i;
  assign last_k   = (k_q + 1'b1) == fill_q;
  assign rel_en   = n_q < MATCH_W'(MAX_MATCHES);
  assign raddr    = wslot_q - fill_q[ADDR_W-1:0] + k_q[ADDR_W-1:0];

  always_comb begin
    new_entry.id      = in_data_i.kf_id;
    new_entry.time_ms = in_data_i.time_ms;
    new_entry.pos.x   = in_data_i.pos_x;
    new_entry.pos.y   = in_data_i.pos_y;
    new_entry.pos.z   = in_data_i.pos_z;
    new_entry.quat.w  = clamp_q(in_data_i.quat_w);
    new_entry.quat.x  = clamp_q(in_data_i.quat_x);
    new_entry.quat.y  = clamp_q(in_data_i.quat_y);
    new_entry.quat.z  = clamp_q(in_data_i.quat_z);
    skip_new = have_q && (absdiff16(in_data_i.kf_id, mnew_q) <= id_skip_q);
  end

  always_comb begin
    dx = $signed({rd_entry.pos.x[31], rd_entry.pos.x}) - $signed({kf_q.pos.x[31], kf_q.pos.x});
    dy = $signed({rd_entry.pos.y[31], rd_entry.pos.y}) - $signed({kf_q.pos.y[31], kf_q.pos.y});
    dz = $signed({rd_entry.pos.z[31], rd_entry.pos.z}) - $signed({kf_q.pos.z[31], kf_q.pos.z});
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    az = dz[32] ? 33'(-dz) : 33'(dz);
    lim_ext = {2'b00, dist_lim_q};
    pass = !(have_q && (absdiff16(rd_entry.id, mold_q) <= id_skip_q))
        && (absdiff16(kf_q.id, rd_entry.id) >= min_gap_q)
        && (absdiff32(kf_q.time_ms, rd_entry.time_ms) >= time_gap_q)
        && (ax < lim_ext) && (ay < lim_ext) && (az < lim_ext);
  end

  always_comb begin
    cur_cand.found    = 1'b1;
    cur_cand.id_new   = kf_q.id;
    cur_cand.id_old   = oid_q;
    cur_cand.rel_x    = rt.x;
    cur_cand.rel_y    = rt.y;
    cur_cand.rel_z    = rt.z;
    cur_cand.rel_qw   = rq.w;
    cur_cand.rel_qx   = rq.x;
    cur_cand.rel_qy   = rq.y;
    cur_cand.rel_qz   = rq.z;
    cur_cand.last     = 1'b0;
    cur_cand.overflow = 1'b0;
    if (pend_v_q) begin
      fin_cand          = pend_q;
      fin_cand.last     = 1'b1;
      fin_cand.overflow = ovf_q;
    end else begin
      fin_cand        = '0;
      fin_cand.id_new = kf_q.id;
      fin_cand.last   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    ram_re          = 1'b0;
    ram_we          = 1'b0;
    advance         = 1'b0;
    pose_cmd.start  = 1'b0;
    pose_cmd.rel_en = rel_en;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (skip_new || fill_q == '0) ? ST_FIN : ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (pass) begin
          pose_cmd.start = 1'b1;
          state_d        = ST_POSE;
        end else begin
          advance = 1'b1;
        end
      end
      ST_POSE: begin
        if (pose_stat.done) begin
          if (pose_stat.hit && rel_en) begin
            state_d = ST_HAND;
          end else begin
            advance = 1'b1;
          end
        end
      end
      ST_HAND: begin
        if (out_free) begin
          advance = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (advance) begin
      state_d = last_k ? ST_FIN : ST_READ;
    end
  end

  assign in_xfer = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_gap_q  <= RST_TIME_GAP;
      dist_lim_q  <= RST_DIST_LIM;
      min_gap_q   <= RST_MIN_GAP;
      id_skip_q   <= RST_ID_SKIP;
      fill_q      <= '0;
      wslot_q     <= '0;
      k_q         <= '0;
      have_q      <= 1'b0;
      mnew_q      <= '0;
      mold_q      <= '0;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TIME_GAP: time_gap_q <= cfg_wdata_i;
          CFG_DIST_LIM: dist_lim_q <= cfg_wdata_i[30:0];
          CFG_MIN_GAP:  min_gap_q  <= cfg_wdata_i[15:0];
          CFG_ID_SKIP:  id_skip_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if ((state_q == ST_HAND && out_free && pend_v_q) || ram_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_xfer) begin
        k_q   <= '0;
        n_q   <= '0;
        ovf_q <= 1'b0;
      end
      if (advance) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == ST_POSE && pose_stat.done && pose_stat.hit) begin
        have_q <= 1'b1;
        mnew_q <= kf_q.id;
        mold_q <= oid_q;
        if (!rel_en) begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == ST_HAND && out_free) begin
        pend_v_q <= 1'b1;
        n_q      <= n_q + 1'b1;
      end
      if (ram_we) begin
        pend_v_q    <= 1'b0;
        wslot_q     <= wslot_q + 1'b1;
        if (fill_q != CNT_W'(KF_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kf_q <= new_entry;
    end
    if (state_q == ST_CHECK && pass) begin
      oid_q <= rd_entry.id;
      qo_q  <= rd_entry.quat;
      d_q.x <= dx[31:0];
      d_q.y <= dy[31:0];
      d_q.z <= dz[31:0];
    end
    if (state_q == ST_HAND && out_free) begin
      if (pend_v_q) begin
        out_q <= pend_q;
      end
      pend_q <= cur_cand;
    end
    if (ram_we) begin
      out_q <= fin_cand;
    end
  end

  lccf_ram #(
    .WIDTH($bits(store_entry_t)),
    .DEPTH(KF_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wslot_q),
    .wdata_i(kf_q),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  lccf_pose_unit u_pose (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (pose_cmd),
    .qn_i  (kf_q.quat),
    .qo_i  (qo_q),
    .d_i   (d_q),
    .lim_i (dist_lim_q),
    .stat_o(pose_stat),
    .rq_o  (rq),
    .rt_o  (rt)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/lccf_checker.sv */
// Port-level checker for the loop closure candidate finder, bound to the top.
// Depends on lccf_pkg and loop_closure_candidate_finder_top.
`timescale 1ns / 1ps
module lccf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lccf_pkg::cand_out_t out_data_o
);
  import lccf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready right after a keyframe transfer");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.last && out_data_o.id_old == 16'd0)
    else $error("empty result is not a lone final result");

  a_overflow_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.last && out_data_o.found)
    else $error("overflow flag outside the final candidate");

endmodule

bind loop_closure_candidate_finder_top lccf_checker u_lccf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
